// ----- hw/rtl/point_in_polygon_ray_cast_core_macros.svh -----
// Assertion macros for the point-in-polygon core.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef POINT_IN_POLYGON_RAY_CAST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon ray casting core.
// No dependencies; used by the edge tester and the top level.
package pip_pkg;

  // Coordinate width, fixed by the vertex and query fields.
  localparam int COORD_BITS = 16;
  // The ray ends one past the largest coordinate.
  localparam int RAY_END_X = 32768;
  // Signed width that holds the ray end minus any coordinate.
  localparam int RAY_BITS = COORD_BITS + 2;

  // Codes of the decided_by field.
  localparam logic [1:0] DEC_PARITY = 2'd0;
  localparam logic [1:0] DEC_EDGE   = 2'd1;
  localparam logic [1:0] DEC_SHORT  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Input word: one polygon vertex plus the query point.
  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t query_x;
    coord_t query_y;
    logic   first_vertex;
    logic   last_vertex;
  } pip_in_t;

  // Result word.
  typedef struct packed {
    logic       inside_res;
    logic [1:0] decided_by;
  } pip_out_t;

  // One edge from a to b, tested against the ray from q.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t qx;
    coord_t qy;
  } pip_edge_t;

  // Edge test outcome: crosses the ray, collinear with q, q on the edge box.
  typedef struct packed {
    logic hit;
    logic col;
    logic on;
  } pip_hit_t;

endpackage

// ----- hw/rtl/point_in_polygon_ray_cast_core.sv -----
// Channel | Ports                          | Word
// input   | in_valid, in_stall, in_word    | pip_in_t: one vertex, query point, markers
// result  | out_valid, out_stall, out_word | pip_out_t: inside flag and decision code
// One vertex word can be accepted in every cycle in which in_stall is low.
// Stages: input register, then both edge tests and the answer update, then the result register.
// A last vertex passes the input register, then the result register, to its result word.
// Reset (synchronous, rst_n low) clears both valids and the polygon state.
// A stalled result holds the result register; a last vertex behind it waits in the input
// register and stalls the input, while words without a result still pass.
module point_in_polygon_ray_cast_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pip_pkg::pip_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pip_pkg::pip_out_t out_word
);
  import pip_pkg::*;

  typedef struct packed {
    logic parity;
    logic fixed;
    logic answer;
  } pip_acc_t;

  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_FULL = 2'd3;

  // One edge applied to the running answer.
  function automatic pip_acc_t apply_edge(input pip_acc_t s, input pip_hit_t h);
    pip_acc_t r;
    r = s;
    if (!s.fixed && h.hit) begin
      if (h.col) begin
        r.fixed  = 1'b1;
        r.answer = h.on;
      end else begin
        r.parity = ~s.parity;
      end
    end
    return r;
  endfunction

  logic      rdy0, rdy1, acc, leave0;
  coord_t    held_qx_r, held_qy_r, first_px_r, first_py_r, prev_px_r, prev_py_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic      v0_r;
  logic      first0_r, last0_r, full0_r;
  pip_edge_t edge_a_nxt, edge_b_nxt, edge_a_r, edge_b_r;
  pip_hit_t  hit_a, hit_b;
  pip_acc_t  state_r, base, after_a, after_b;
  logic      out_valid_r;
  pip_out_t  out_word_r, out_word_nxt;
  coord_t    q_x, q_y;

  // Ready chain: the input register moves when empty or when its word moves on.
  // Words with no result leave without the result register.
  always_comb begin
    rdy1   = !out_valid_r || !out_stall;
    rdy0   = !v0_r || !last0_r || rdy1;
    acc    = in_valid && rdy0;
    leave0 = v0_r && rdy0;
  end

  assign in_stall = !rdy0;

  // Edges carried by the incoming word: previous to current, current to first.
  always_comb begin
    q_x = in_word.first_vertex ? in_word.query_x : held_qx_r;
    q_y = in_word.first_vertex ? in_word.query_y : held_qy_r;
    edge_a_nxt = '{ax: prev_px_r, ay: prev_py_r, bx: in_word.vertex_x,
                   by: in_word.vertex_y, qx: q_x, qy: q_y};
    edge_b_nxt = '{ax: in_word.vertex_x, ay: in_word.vertex_y,
                   bx: in_word.first_vertex ? in_word.vertex_x : first_px_r,
                   by: in_word.first_vertex ? in_word.vertex_y : first_py_r,
                   qx: q_x, qy: q_y};
    if (in_word.first_vertex) begin
      cnt_nxt = CNT_ONE;
    end else if (cnt_r == CNT_FULL) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  // Polygon front state and input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_qx_r  <= '0;
      held_qy_r  <= '0;
      first_px_r <= '0;
      first_py_r <= '0;
      prev_px_r  <= '0;
      prev_py_r  <= '0;
      cnt_r      <= '0;
      v0_r       <= 1'b0;
    end else begin
      if (acc) begin
        if (in_word.first_vertex) begin
          held_qx_r  <= in_word.query_x;
          held_qy_r  <= in_word.query_y;
          first_px_r <= in_word.vertex_x;
          first_py_r <= in_word.vertex_y;
        end
        prev_px_r <= in_word.vertex_x;
        prev_py_r <= in_word.vertex_y;
        cnt_r     <= cnt_nxt;
      end
      if (rdy0) begin
        v0_r <= in_valid;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (rdy0) begin
      edge_a_r <= edge_a_nxt;
      edge_b_r <= edge_b_nxt;
      first0_r <= in_word.first_vertex;
      last0_r  <= in_word.last_vertex;
      full0_r  <= (cnt_nxt == CNT_FULL);
    end
  end

  pip_edge_test u_edge_a (
    .edge_in (edge_a_r),
    .hit_out (hit_a)
  );

  pip_edge_test u_edge_b (
    .edge_in (edge_b_r),
    .hit_out (hit_b)
  );

  // Running answer: a first vertex restarts it and skips edge a; edge b counts only on a last vertex.
  always_comb begin
    base    = first0_r ? '0 : state_r;
    after_a = first0_r ? base : apply_edge(base, hit_a);
    after_b = last0_r ? apply_edge(after_a, hit_b) : after_a;
    if (!full0_r) begin
      out_word_nxt.inside_res = 1'b0;
      out_word_nxt.decided_by = DEC_SHORT;
    end else if (after_b.fixed) begin
      out_word_nxt.inside_res = after_b.answer;
      out_word_nxt.decided_by = DEC_EDGE;
    end else begin
      out_word_nxt.inside_res = after_b.parity;
      out_word_nxt.decided_by = DEC_PARITY;
    end
  end

  // Answer state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (leave0) begin
        state_r <= after_b;
      end
      if (rdy1) begin
        out_valid_r <= v0_r && last0_r;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "point_in_polygon_ray_cast_core_macros.svh"

  `PIP_ASSERT_IMPL(a_short_is_outside,
                   out_valid_r && out_word_r.decided_by == DEC_SHORT,
                   !out_word_r.inside_res, "short polygon reported inside")
  `PIP_ASSERT_NEXT(a_first_sets_count, acc && in_word.first_vertex,
                   cnt_r == CNT_ONE, "first vertex did not restart the count")
  `PIP_ASSERT_IMPL(a_stall_only_when_full, in_stall,
                   v0_r && last0_r && out_valid_r, "input stalled with room in the pipeline")
  `PIP_ASSERT_NEXT(a_fixed_holds, state_r.fixed && !(leave0 && first0_r),
                   state_r.fixed, "fixed answer released within a polygon")
  `PIP_ASSERT_NEXT(a_no_result_without_last, v0_r && rdy1 && !last0_r,
                   !out_valid_r, "result raised by a word that is not a last vertex")

endmodule

// ----- hw/rtl/pip_edge_test.sv -----
// Combinational edge tester: orientation products, signs and crossing flags.
// Depends on pip_pkg for the edge and flag types and the ray end constant.
module pip_edge_test (
  input  pip_pkg::pip_edge_t edge_in,
  output pip_pkg::pip_hit_t  hit_out
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int RW = RAY_BITS;
  localparam int PW = DW + RW + 1;
  localparam logic signed [RW-1:0] RAY_END = RW'(RAY_END_X);

  // True when v lies between e0 and e1, in either order.
  function automatic logic between(input logic signed [RW-1:0] v,
                                   input logic signed [RW-1:0] e0,
                                   input logic signed [RW-1:0] e1);
    return (v >= e0 && v <= e1) || (v >= e1 && v <= e0);
  endfunction

  logic signed [DW-1:0]      dy_ab, dx_ab, dx_qb, dy_qb, dy_qa, dx_bq, dx_qa, dy_bq;
  logic signed [RW-1:0]      dx_rb, dx_rq;
  logic signed [RW-1:0]      ax_w, ay_w, bx_w, by_w, qx_w, qy_w;
  logic signed [2*DW-1:0]    p_q1, p_cm, p_c1, p_c2;
  logic signed [DW+RW-1:0]   p_q2;
  logic                      z3, n3, z4, n4;
  logic                      s1, s2, s3, s4;
  logic signed [PW-1:0]      o1, o2, oc;
  logic                      z1, n1, z2, n2;

  // Coordinate differences, widened so they cannot wrap.
  always_comb begin
    dy_ab = DW'(edge_in.by) - DW'(edge_in.ay);
    dx_ab = DW'(edge_in.bx) - DW'(edge_in.ax);
    dx_qb = DW'(edge_in.qx) - DW'(edge_in.bx);
    dy_qb = DW'(edge_in.qy) - DW'(edge_in.by);
    dy_qa = DW'(edge_in.qy) - DW'(edge_in.ay);
    dx_bq = DW'(edge_in.bx) - DW'(edge_in.qx);
    dx_qa = DW'(edge_in.qx) - DW'(edge_in.ax);
    dy_bq = DW'(edge_in.by) - DW'(edge_in.qy);
    dx_rb = RAY_END - RW'(edge_in.bx);
    dx_rq = RAY_END - RW'(edge_in.qx);
    ax_w  = RW'(edge_in.ax);
    ay_w  = RW'(edge_in.ay);
    bx_w  = RW'(edge_in.bx);
    by_w  = RW'(edge_in.by);
    qx_w  = RW'(edge_in.qx);
    qy_w  = RW'(edge_in.qy);
  end

  // Products for orient(a,b,q), orient(a,b,ray end) and orient(a,q,b).
  always_comb begin
    p_q1 = dy_ab * dx_qb;
    p_q2 = dy_ab * dx_rb;
    p_cm = dx_ab * dy_qb;
    p_c1 = dy_qa * dx_bq;
    p_c2 = dx_qa * dy_bq;
  end

  // The ray is horizontal, so orient(q, ray end, a) is (end - qx) * (qy - ay):
  // its sign follows from the factor signs with no multiplier.
  always_comb begin
    z3 = (dx_rq == '0) || (dy_qa == '0);
    n3 = !z3 && (dx_rq[RW-1] != dy_qa[DW-1]);
    z4 = (dx_rq == '0) || (dy_qb == '0);
    n4 = !z4 && (dx_rq[RW-1] != dy_qb[DW-1]);
    s1 = between(qx_w, ax_w, bx_w) && between(qy_w, ay_w, by_w);
    s2 = between(RAY_END, ax_w, bx_w) && between(qy_w, ay_w, by_w);
    s3 = between(ax_w, qx_w, RAY_END) && (ay_w == qy_w);
    s4 = between(bx_w, qx_w, RAY_END) && (by_w == qy_w);
  end

  // Orientation signs and the segment crossing decision.
  always_comb begin
    o1 = PW'(p_q1) - PW'(p_cm);
    o2 = PW'(p_q2) - PW'(p_cm);
    oc = PW'(p_c1) - PW'(p_c2);
    z1 = (o1 == '0);
    n1 = o1[PW-1];
    z2 = (o2 == '0);
    n2 = o2[PW-1];
    hit_out.hit = (((z1 != z2) || (n1 != n2)) && ((z3 != z4) || (n3 != n4)))
                  || (z1 && s1) || (z2 && s2) || (z3 && s3) || (z4 && s4);
    hit_out.col = (oc == '0);
    hit_out.on  = s1;
  end

endmodule
